// ----- hw/rtl/hclp_pkg.sv -----
package hclp_pkg;

  localparam int unsigned LEN_W = 31;

  localparam logic [LEN_W-1:0] LIM_DIV10 = 31'd214748364;
  localparam logic [3:0]       LIM_LAST  = 4'd7;

  typedef enum logic [2:0] {
    PS_S1 = 3'd1,
    PS_S2 = 3'd2,
    PS_S3 = 3'd3,
    PS_S4 = 3'd4
  } pst_t;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_BAD      = 2'd2,
    ST_BIG      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_OTHER,
    CL_DIGIT,
    CL_COMMA,
    CL_BLANK
  } cls_t;

  typedef struct packed {
    pst_t             pst;
    logic [LEN_W-1:0] acc;
    logic [LEN_W-1:0] first;
    logic             have_first;
    status_t          fail;
  } ctx_t;

  typedef struct packed {
    logic             final_res;
    status_t          status;
    logic [LEN_W-1:0] length;
  } res_t;

  localparam ctx_t CTX_RESET = '{
    pst:        PS_S1,
    acc:        '0,
    first:      '0,
    have_first: 1'b0,
    fail:       ST_PENDING
  };

  function automatic cls_t classify(input logic [7:0] c);
    cls_t cl;
    begin
      case (c) inside
        [8'h30:8'h39]: cl = CL_DIGIT;
        8'h2c:         cl = CL_COMMA;
        8'h09, 8'h20:  cl = CL_BLANK;
        default:       cl = CL_OTHER;
      endcase
      return cl;
    end
  endfunction

endpackage

// ----- hw/rtl/http_content_length_parser.sv -----
// Content-Length value parser. Feed the header value one byte per item on
// in_octet, then one item with in_end_mark high. Every item gives exactly one
// result: byte items report pending or the first failure seen so far; the
// end-marker item has out_final_res high and carries the verdict, with the
// length when accepted, and returns the parser to its start state. The byte
// is classified, the automaton steps and the number is multiplied by ten in
// a single pass into the result register, so a new item is taken every
// cycle while the result register can be emptied.
module http_content_length_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_octet,
  input  logic        in_end_mark,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_final_res,
  output logic [1:0]  out_status,
  output logic [30:0] out_length
);
  import hclp_pkg::*;

  ctx_t ctx_r;
  ctx_t ctx_nxt;
  res_t res_nxt;
  res_t res_r;
  logic out_valid_r;
  logic in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  hclp_step u_step (
    .ctx      (ctx_r),
    .octet    (in_octet),
    .end_mark (in_end_mark),
    .ctx_nxt  (ctx_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= CTX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ctx_r <= ctx_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_final_res = res_r.final_res;
  assign out_status    = res_r.status;
  assign out_length    = res_r.length;

  // end marker returns the parser to its start state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_mark) |=> (ctx_r == CTX_RESET))
    else $error("state not cleared after end marker");

  // a failure stays latched until the end marker
  a_fail_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_end_mark && ctx_r.fail != ST_PENDING) |=> (ctx_r.fail == $past(ctx_r.fail)))
    else $error("latched failure changed");

  // accepted verdict only on the final result
  a_accept_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_ACCEPTED) |-> res_r.final_res)
    else $error("accepted status on a byte result");

  // byte results never carry a length
  a_byte_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.final_res) |-> (res_r.length == '0))
    else $error("nonzero length on a byte result");

endmodule

// ----- hw/rtl/hclp_step.sv -----
module hclp_step (
  input  hclp_pkg::ctx_t ctx,
  input  logic [7:0]     octet,
  input  logic           end_mark,
  output hclp_pkg::ctx_t ctx_nxt,
  output hclp_pkg::res_t res
);
  import hclp_pkg::*;

  pst_t             st;
  logic [3:0]       dig;
  logic [LEN_W-1:0] acc_x10;
  logic             over;
  logic             match;

  always_comb begin
    case (ctx.pst)
      PS_S2:   st = PS_S2;
      PS_S3:   st = PS_S3;
      PS_S4:   st = PS_S4;
      default: st = PS_S1;
    endcase
  end

  assign dig     = octet[3:0];
  // acc * 10 + digit, kept to 31 bits
  assign acc_x10 = {ctx.acc[LEN_W-4:0], 3'b000} + {ctx.acc[LEN_W-2:0], 1'b0}
                   + {{(LEN_W-4){1'b0}}, dig};
  assign over    = (ctx.acc > LIM_DIV10) || ((ctx.acc == LIM_DIV10) && (dig > LIM_LAST));
  assign match   = !ctx.have_first || (ctx.first == ctx.acc);

  always_comb begin
    ctx_nxt       = ctx;
    res.final_res = 1'b0;
    res.status    = ctx.fail;
    res.length    = '0;
    if (end_mark) begin
      res.final_res = 1'b1;
      if (ctx.fail != ST_PENDING) begin
        res.status = ctx.fail;
      end else if (st == PS_S1) begin
        res.status = ST_BAD;
      end else if (st == PS_S2 && !match) begin
        res.status = ST_BAD;
      end else begin
        res.status = ST_ACCEPTED;
        res.length = (st == PS_S2) ? ctx.acc : ctx.first;
      end
      ctx_nxt = CTX_RESET;
    end else begin
      if (ctx.fail == ST_PENDING) begin
        case (classify(octet))
          CL_DIGIT: begin
            if (st == PS_S3) begin
              ctx_nxt.fail = ST_BAD;
            end else if (over) begin
              ctx_nxt.fail = ST_BIG;
            end else begin
              ctx_nxt.acc = acc_x10;
              ctx_nxt.pst = PS_S2;
            end
          end
          CL_COMMA, CL_BLANK: begin
            if (st == PS_S2) begin
              // number finished: record it or compare with the first
              if (match) begin
                ctx_nxt.first      = ctx.acc;
                ctx_nxt.have_first = 1'b1;
                ctx_nxt.acc        = '0;
                ctx_nxt.pst        = (classify(octet) == CL_COMMA) ? PS_S4 : PS_S3;
              end else begin
                ctx_nxt.fail = ST_BAD;
              end
            end else if (st == PS_S1) begin
              ctx_nxt.pst = PS_S1;
            end else if (classify(octet) == CL_COMMA) begin
              ctx_nxt.pst = PS_S4;
            end else begin
              ctx_nxt.pst = st;
            end
          end
          default: begin
            ctx_nxt.fail = ST_BAD;
          end
        endcase
      end
      res.status = ctx_nxt.fail;
    end
  end

endmodule

// ----- test/http_content_length_parser_tb.sv -----
`timescale 1ns / 1ps

module http_content_length_parser_tb;
  import hclp_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int HDR_ITEMS  = 1125;
  localparam int PHASE_A    = 380;
  localparam int PHASE_B    = 760;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 80;
  localparam int DRAIN_AT   = 900;
  localparam int STALL_MAX  = 2000;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [7:0] octet;
    logic       endm;
  } hdr_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_octet = 8'h00;
  logic        in_end_mark = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_final_res;
  logic [1:0]  out_status;
  logic [30:0] out_length;

  http_content_length_parser u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_octet     (in_octet),
    .in_end_mark  (in_end_mark),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_final_res(out_final_res),
    .out_status   (out_status),
    .out_length   (out_length)
  );

  always #10 clk = ~clk;

  hdr_item_t hdr_bytes_q[$];
  res_t      predicted_res_q[$];

  int n_in = 0;
  int n_out = 0;
  int n_err = 0;
  int send_idle;
  int recv_idle;
  int hold_cnt = 0;
  logic hold_done = 1'b0;
  logic drained = 1'b0;
  int stall_cnt = 0;

  // parser shadow state
  pst_t             ps_state = PS_S1;
  logic [LEN_W-1:0] acc_val = '0;
  logic [LEN_W-1:0] first_val = '0;
  logic             have_first = 1'b0;
  status_t          fail_code = ST_PENDING;

  always_comb begin
    if (n_in < PHASE_A) begin
      send_idle = 6;
      recv_idle = 57;
    end else if (n_in < PHASE_B) begin
      send_idle = 57;
      recv_idle = 6;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  task automatic parse_byte(input logic [7:0] c, input logic endm, output res_t r);
    pst_t    nx;
    status_t fc;
    logic [3:0] d;
    begin
      r.final_res = 1'b0;
      r.status = ST_PENDING;
      r.length = '0;
      if (endm) begin
        r.final_res = 1'b1;
        if (fail_code != ST_PENDING) begin
          r.status = fail_code;
        end else if (ps_state == PS_S1) begin
          r.status = ST_BAD;
        end else if (ps_state == PS_S2 && have_first && first_val != acc_val) begin
          r.status = ST_BAD;
        end else begin
          r.status = ST_ACCEPTED;
          r.length = (ps_state == PS_S2) ? acc_val : first_val;
        end
        ps_state = PS_S1;
        acc_val = '0;
        first_val = '0;
        have_first = 1'b0;
        fail_code = ST_PENDING;
      end else begin
        if (fail_code == ST_PENDING) begin
          fc = ST_PENDING;
          nx = ps_state;
          if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 4'(c - CH_ZERO);
            if (ps_state == PS_S3) begin
              fc = ST_BAD;
            end else if (acc_val > LIM_DIV10 || (acc_val == LIM_DIV10 && d > LIM_LAST)) begin
              fc = ST_BIG;
            end else begin
              acc_val = acc_val * 31'd10 + {27'd0, d};
              nx = PS_S2;
            end
          end else if (c == CH_COMMA || c == CH_SPACE || c == CH_TAB) begin
            if (ps_state == PS_S2) begin
              // number just finished: must match the first one in the list
              if (have_first && first_val != acc_val) begin
                fc = ST_BAD;
              end else begin
                first_val = acc_val;
                have_first = 1'b1;
                acc_val = '0;
                nx = (c == CH_COMMA) ? PS_S4 : PS_S3;
              end
            end else if (c == CH_COMMA && ps_state == PS_S3) begin
              nx = PS_S4;
            end
          end else begin
            fc = ST_BAD;
          end
          if (fc != ST_PENDING) fail_code = fc;
          else ps_state = nx;
        end
        r.status = fail_code;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    begin
      if (n_err < MAX_PRINTS)
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got_v, want_v);
      n_err++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drv
    hdr_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (!drained && n_in >= DRAIN_AT) begin
        // hold off until every result is back
        in_valid <= 1'b0;
        if (!in_valid && n_in == n_out) drained <= 1'b1;
      end else if (hdr_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        item = hdr_bytes_q.pop_front();
        in_valid <= 1'b1;
        in_octet <= item.octet;
        in_end_mark <= item.endm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    res_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_octet, in_end_mark, want);
        predicted_res_q.push_back(want);
        n_in <= n_in + 1;
      end
      if (out_valid && out_ready) begin
        n_out <= n_out + 1;
        if (predicted_res_q.size() == 0) begin
          report_mismatch("unexpected result, final_res", out_final_res, 0);
        end else begin
          want = predicted_res_q.pop_front();
          if (out_final_res !== want.final_res)
            report_mismatch("final_res", out_final_res, want.final_res);
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_length !== want.length)
            report_mismatch("length", out_length, want.length);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_MAX) begin
          $display("http_content_length_parser_tb: errors");
          $finish;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    hdr_item_t item;
    begin
      item.octet = b;
      item.endm = 1'b0;
      hdr_bytes_q.push_back(item);
    end
  endtask

  task automatic push_end();
    hdr_item_t item;
    begin
      item.octet = 8'($urandom_range(0, 255));
      item.endm = 1'b1;
      hdr_bytes_q.push_back(item);
    end
  endtask

  task automatic push_digits(input longint unsigned v);
    logic [7:0] digs[$];
    longint unsigned t;
    begin
      t = v;
      do begin
        digs.push_front(CH_ZERO + 8'(t % 10));
        t = t / 10;
      end while (t != 0);
      foreach (digs[i]) push_byte(digs[i]);
    end
  endtask

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] blank_or_comma();
    return ($urandom_range(0, 2) == 0) ? CH_COMMA : any_blank();
  endfunction

  function automatic longint unsigned pick_value();
    longint unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 99);
      3, 4:    v = $urandom_range(0, 99999);
      5:       v = 64'($urandom & 32'h7fff_ffff);
      6:       v = 64'd2147483647 - $urandom_range(0, 9);
      7:       v = 64'd2147483648 + $urandom_range(0, 9);
      8:       v = {$urandom, $urandom} % 64'd100000000000;
      default: v = 0;
    endcase
    return v;
  endfunction

  task automatic add_header();
    int n_nums;
    longint unsigned v;
    logic [7:0] c;
    begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: arbitrary bytes mixed with digits, commas and blanks
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) begin
            c = 8'($urandom_range(0, 255));
          end else begin
            case ($urandom_range(0, 3))
              0:       c = CH_ZERO + 8'($urandom_range(0, 9));
              1:       c = CH_COMMA;
              default: c = any_blank();
            endcase
          end
          push_byte(c);
        end
      end else begin
        v = pick_value();
        n_nums = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
        repeat ($urandom_range(0, 2)) push_byte(blank_or_comma());
        for (int i = 0; i < n_nums; i++) begin
          if (i != 0) begin
            repeat ($urandom_range(0, 1)) push_byte(any_blank());
            push_byte(CH_COMMA);
            repeat ($urandom_range(0, 2)) push_byte(blank_or_comma());
          end
          if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
          push_digits((i != 0 && $urandom_range(0, 9) == 0) ? v + 1 : v);
        end
        repeat ($urandom_range(0, 2)) push_byte(blank_or_comma());
        case ($urandom_range(0, 19))
          0: begin
            do c = 8'($urandom_range(0, 255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COMMA || c == CH_SPACE ||
                   c == CH_TAB);
            push_byte(c);
          end
          1: begin
            push_byte(any_blank());
            push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          default: ;
        endcase
      end
      push_end();
    end
  endtask

  initial begin
    // empty value
    push_end();
    // largest length
    push_digits(64'd2147483647);
    push_end();
    // list with unequal numbers
    push_digits(9);
    push_byte(CH_COMMA);
    push_digits(8);
    push_end();
    // nul and high byte, failure stays latched
    push_byte(8'h00);
    push_byte(8'hff);
    push_end();
    // blanks around an equal list
    push_byte(CH_SPACE);
    push_digits(3);
    push_byte(CH_COMMA);
    push_byte(CH_TAB);
    push_digits(3);
    push_end();

    while (hdr_bytes_q.size() < HDR_ITEMS) add_header();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (hdr_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (predicted_res_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (n_err == 0)
      $display("http_content_length_parser_tb: clean");
    else
      $display("http_content_length_parser_tb: errors");
    $finish;
  end

endmodule

// ----- http_content_length_parser.f -----
hw/rtl/hclp_pkg.sv
hw/rtl/hclp_step.sv
hw/rtl/http_content_length_parser.sv
test/http_content_length_parser_tb.sv
